FILE: sv/bfara_pkg.sv
// shared constants and types for the best-fit aligned range allocator
// no dependencies
package bfara_pkg;

    localparam int FreeSlotsDef = 16;
    localparam logic [31:0] PoolSizeReset = 32'd65536;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // per-cell fit result, travels down the chain
    typedef struct packed {
        logic        found;
        logic [32:0] len;
        logic [32:0] aligned;
        logic [32:0] start;
        logic [7:0]  idx;      // slot of the best fit, up to 256 slots
    } t_best;

    // command from the sequencer to the cells
    typedef struct packed {
        logic        shift;
        logic [32:0] size;
        logic [31:0] mask;
    } t_cell_ctl;

endpackage

FILE: sv/bfara_cell.sv
// one slot of the free list: stores a range, compares it against the request and
// hands the registered best fit so far to its neighbor every cycle; depends on bfara_pkg
module bfara_cell (
    input  logic                 i_clk,
    input  logic [7:0]           i_idx,
    input  logic                 i_valid,
    input  bfara_pkg::t_cell_ctl i_ctl,
    input  logic                 i_sel,
    input  logic                 i_wr,
    input  logic [31:0]          i_wr_start,
    input  logic [31:0]          i_wr_len,
    input  logic [31:0]          i_nb_start,
    input  logic [31:0]          i_nb_len,
    input  bfara_pkg::t_best     i_best,
    output bfara_pkg::t_best     o_best,
    output logic [31:0]          o_start,
    output logic [31:0]          o_len
);

    logic [31:0]      r_start;
    logic [31:0]      r_len;
    bfara_pkg::t_best r_best;
    bfara_pkg::t_best n_best;
    logic [32:0]      w_al;
    logic [33:0]      w_end;
    logic             w_fit;

    always_comb begin
        w_al  = ({1'b0, r_start} + {1'b0, i_ctl.mask}) & ~{1'b0, i_ctl.mask};
        w_end = {1'b0, w_al} + {1'b0, i_ctl.size};
        w_fit = i_valid && (w_end <= ({2'b0, r_start} + {2'b0, r_len}));
        n_best = i_best;
        if (w_fit && (!i_best.found || {1'b0, r_len} < i_best.len)) begin
            n_best.found   = 1'b1;
            n_best.len     = {1'b0, r_len};
            n_best.aligned = w_al;
            n_best.start   = {1'b0, r_start};
            n_best.idx     = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
        if (i_wr) begin
            r_start <= i_wr_start;
            r_len   <= i_wr_len;
        end else if (i_ctl.shift && i_sel) begin
            r_start <= i_nb_start;
            r_len   <= i_nb_len;
        end
    end

    assign o_best  = r_best;
    assign o_start = r_start;
    assign o_len   = r_len;

endmodule

FILE: sv/best_fit_aligned_range_allocator.sv
// top level of the best-fit aligned range allocator: sequencer, bump pointer, cell chain
// depends on bfara_pkg and bfara_cell
//
// channel  | dir | tdata fields (lsb first)              | tuser fields (lsb first)
// s_axis   | in  | size_bytes, align_log2, range_offset  | op
// m_axis   | out | offset                                | status, from_free_list
// cfg      | in  | pool_size                             | -
//
// zero-size requests and frees to a full list answer after the search state, other frees
// after the remove state; an allocate waits in the search state while the best fit walks the
// chain one cell per cycle, then answers at once from the bump pointer, after the remove
// state when the list would overflow, or after the append states for a granted list range.
// a held result stalls the block; the next input transfer can come in the cycle after the
// output transfer. reset clears the count and bump pointer; list contents need no clearing.
module best_fit_aligned_range_allocator #(
    parameter int FREE_SLOTS = bfara_pkg::FreeSlotsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // size_bytes, align_log2, range_offset
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // offset
    output logic [2:0]  m_axis_tuser,   // status, from_free_list
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int IW = $clog2(FREE_SLOTS);
    localparam int CW = $clog2(FREE_SLOTS + 1);
    localparam logic [CW-1:0] Slots = CW'(FREE_SLOTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_RMV  = 3'd2;
    localparam logic [2:0] S_APP1 = 3'd3;
    localparam logic [2:0] S_APP2 = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]    r_state;
    logic [CW-1:0] r_scnt;
    logic [31:0]   r_pool;
    logic [31:0]   r_bump;
    logic [CW-1:0] r_count;
    logic          r_op;
    logic [31:0]   r_size;
    logic [31:0]   r_mask;
    logic [31:0]   r_roff;
    bfara_pkg::t_best r_best;
    logic [IW-1:0] r_bidx;
    logic          r_lead;
    logic          r_trail;
    logic [31:0]   r_off;
    logic [1:0]    r_st;
    logic          r_ffl;
    logic [31:0]   r_ws;
    logic [31:0]   r_wl;

    bfara_pkg::t_best     w_chain [FREE_SLOTS+1];
    logic [31:0]          w_st    [FREE_SLOTS];
    logic [31:0]          w_ln    [FREE_SLOTS];
    bfara_pkg::t_cell_ctl w_ctl;
    logic                 w_wr;
    logic [IW-1:0]        w_widx;

    logic [32:0] w_bal;
    logic [33:0] w_bend;
    logic [32:0] w_gend;
    logic [32:0] w_fend;
    logic [CW:0] w_need;

    assign s_axis_tready = (r_state == S_IDLE) && !m_axis_tvalid;
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_off;
    assign m_axis_tuser  = {r_ffl, r_st};

    always_comb begin
        w_bal  = ({1'b0, r_bump} + {1'b0, r_mask}) & ~{1'b0, r_mask};
        w_bend = {1'b0, w_bal} + {2'b0, r_size};
        w_gend = r_best.aligned + {1'b0, r_size};
        w_fend = {1'b0, r_roff} + {1'b0, r_size};
        w_need = {1'b0, r_count} - (CW+1)'(1) + (CW+1)'(r_best.start < r_best.aligned)
                 + (CW+1)'(w_gend < r_best.start + r_best.len);
    end

    always_comb begin
        w_ctl.shift = (r_state == S_RMV) && (r_op == bfara_pkg::OP_ALLOC) &&
                      (w_need <= {1'b0, Slots});
        w_ctl.size  = {1'b0, r_size};
        w_ctl.mask  = r_mask;
        w_wr   = 1'b0;
        w_widx = r_count[IW-1:0];
        if ((r_state == S_APP1 && r_lead) || (r_state == S_APP2 && r_trail) ||
            (r_state == S_RMV && r_op == bfara_pkg::OP_FREE)) begin
            w_wr = 1'b1;
        end
    end

    assign w_chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < FREE_SLOTS; g++) begin : g_cell
            logic [31:0] nb_s;
            logic [31:0] nb_l;
            if (g == FREE_SLOTS - 1) begin : g_end
                assign nb_s = w_st[g];
                assign nb_l = w_ln[g];
            end else begin : g_mid
                assign nb_s = w_st[g+1];
                assign nb_l = w_ln[g+1];
            end
            bfara_cell u_cell (
                .i_clk      (i_clk),
                .i_idx      (8'(g)),
                .i_valid    (CW'(g) < r_count),
                .i_ctl      (w_ctl),
                .i_sel      (IW'(g) >= r_bidx),
                .i_wr       (w_wr && w_widx == IW'(g)),
                .i_wr_start (r_ws),
                .i_wr_len   (r_wl),
                .i_nb_start (nb_s),
                .i_nb_len   (nb_l),
                .i_best     (w_chain[g]),
                .o_best     (w_chain[g+1]),
                .o_start    (w_st[g]),
                .o_len      (w_ln[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pool  <= bfara_pkg::PoolSizeReset;
            r_bump  <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_pool <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op    <= s_axis_tuser;
                        r_size  <= s_axis_tdata[31:0];
                        r_mask  <= ~(32'hFFFF_FFFF << s_axis_tdata[36:32]);
                        r_roff  <= s_axis_tdata[68:37];
                        r_scnt  <= '0;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    r_scnt <= r_scnt + CW'(1);
                    // the last cell holds the full search once the whole chain has been walked
                    if (r_size == '0 || r_op == bfara_pkg::OP_FREE || r_scnt == Slots) begin
                        r_best <= w_chain[FREE_SLOTS];
                        r_bidx <= w_chain[FREE_SLOTS].idx[IW-1:0];
                        r_off  <= '0;
                        r_st   <= bfara_pkg::ST_OK;
                        r_ffl  <= 1'b0;
                        r_ws   <= r_roff;
                        r_wl   <= w_fend[32] ? (32'd0 - r_roff) : r_size;
                        r_state <= S_RMV;
                        if (r_size == '0) begin
                            r_state <= S_OUT;
                        end else if (r_op == bfara_pkg::OP_FREE) begin
                            if (r_count >= Slots) begin
                                r_st    <= bfara_pkg::ST_FULL;
                                r_state <= S_OUT;
                            end
                        end else if (!w_chain[FREE_SLOTS].found) begin
                            r_state <= S_OUT;
                            if (w_bend > {2'b0, r_pool}) begin
                                r_st <= bfara_pkg::ST_EXHAUSTED;
                            end else begin
                                r_off  <= w_bal[31:0];
                                r_bump <= w_bend[31:0];
                            end
                        end
                    end
                end
                S_RMV: begin
                    if (r_op == bfara_pkg::OP_FREE) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_OUT;
                    end else if (w_need > {1'b0, Slots}) begin
                        r_st    <= bfara_pkg::ST_FULL;
                        r_state <= S_OUT;
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_lead  <= r_best.start < r_best.aligned;
                        r_trail <= w_gend < r_best.start + r_best.len;
                        r_ws    <= r_best.start[31:0];
                        r_wl    <= r_best.aligned[31:0] - r_best.start[31:0];
                        r_off   <= r_best.aligned[31:0];
                        r_ffl   <= 1'b1;
                        r_state <= S_APP1;
                    end
                end
                S_APP1: begin
                    if (r_lead) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_ws    <= w_gend[31:0];
                    r_wl    <= r_best.start[31:0] + r_best.len[31:0] - w_gend[31:0];
                    r_state <= S_APP2;
                end
                S_APP2: begin
                    if (r_trail) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/bfara_checker.sv
// port-level checks for the allocator, bound to the top level
// depends on bfara_pkg
module bfara_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [2:0]  m_axis_tuser
);

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result in cycle after transfer");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)
        else $error("bad status");

    a_flag_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tuser[1:0] == bfara_pkg::ST_OK)
        else $error("free-list grant with error");

endmodule

bind best_fit_aligned_range_allocator bfara_checker u_bfara_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/tb_best_fit_aligned_range_allocator.sv
// testbench for the best-fit aligned range allocator: directed and random requests,
// predicted against a local model of the free list and bump pointer
// depends on bfara_pkg and the allocator rtl
module tb_best_fit_aligned_range_allocator;

    localparam int SLOTS = bfara_pkg::FreeSlotsDef;

    typedef struct packed {
        logic [31:0] offset;
        logic [1:0]  status;
        logic        ffl;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    best_fit_aligned_range_allocator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // allocator image
    logic [31:0] pool_bytes;
    logic [31:0] bump_ptr;
    logic [31:0] rng_start [SLOTS];
    logic [31:0] rng_len [SLOTS];
    int          rng_count;

    t_grant      grants_due[$];
    int          n_err;
    int          n_sent;
    int          n_seen;
    int          n_list_hits;
    int          n_exhaust;
    int          n_full;
    bit          stall_on;
    bit          hold_rx;
    bit          quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_grant predict_grant(logic op, logic [31:0] sz, logic [4:0] al,
                                             logic [31:0] roff);
        t_grant      g;
        logic [32:0] amask;
        logic [32:0] s, l, a, b_len, b_al, e, ge;
        int          best;
        bit          found;
        int          need;
        g = '0;
        found = 0;
        best = 0;
        b_len = '0;
        b_al = '0;
        if (sz == 0) return g;
        if (op == bfara_pkg::OP_FREE) begin
            if (rng_count >= SLOTS) begin
                g.status = bfara_pkg::ST_FULL;
                return g;
            end
            l = {1'b0, sz};
            if ({1'b0, roff} + l > 33'h1_0000_0000) l = 33'h1_0000_0000 - roff;
            rng_start[rng_count] = roff;
            rng_len[rng_count] = l[31:0];
            rng_count++;
            return g;
        end
        amask = (33'd1 << al) - 33'd1;
        for (int i = 0; i < rng_count; i++) begin
            s = {1'b0, rng_start[i]};
            l = {1'b0, rng_len[i]};
            a = (s + amask) & ~amask;
            if ({1'b0, a} + sz > {1'b0, s} + l) continue;
            if (!found || l < b_len) begin
                found = 1;
                best = i;
                b_len = l;
                b_al = a;
            end
        end
        if (found) begin
            s = {1'b0, rng_start[best]};
            e = s + b_len;
            ge = b_al + sz;
            need = rng_count - 1 + (s < b_al) + (ge < e);
            if (need > SLOTS) begin
                g.status = bfara_pkg::ST_FULL;
                n_full++;
                return g;
            end
            for (int i = best; i + 1 < rng_count; i++) begin
                rng_start[i] = rng_start[i+1];
                rng_len[i] = rng_len[i+1];
            end
            rng_count--;
            if (s < b_al) begin
                rng_start[rng_count] = s[31:0];
                rng_len[rng_count] = b_al[31:0] - s[31:0];
                rng_count++;
            end
            if (ge < e) begin
                rng_start[rng_count] = ge[31:0];
                rng_len[rng_count] = e[31:0] - ge[31:0];
                rng_count++;
            end
            g.offset = b_al[31:0];
            g.ffl = 1'b1;
            n_list_hits++;
            return g;
        end
        a = ({1'b0, bump_ptr} + amask) & ~amask;
        if ({1'b0, a} + sz > {2'b0, pool_bytes}) begin
            g.status = bfara_pkg::ST_EXHAUSTED;
            n_exhaust++;
            return g;
        end
        bump_ptr = a[31:0] + sz;
        g.offset = a[31:0];
        return g;
    endfunction

    task automatic send_request(logic op, logic [31:0] sz, logic [4:0] al, logic [31:0] roff);
        t_grant pred;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b0, roff, al, sz};
        s_axis_tuser <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = predict_grant(op, sz, al, roff);
        grants_due.insert(grants_due.size(), pred);
        n_sent++;
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (grants_due.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_pool(logic [31:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        pool_bytes = v;
        @(posedge i_clk);
    endtask

    // result check
    always @(posedge i_clk) begin
        t_grant got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.offset = m_axis_tdata;
            got.status = m_axis_tuser[1:0];
            got.ffl = m_axis_tuser[2];
            n_seen++;
            if (grants_due.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected transfer %h", got);
            end else begin
                want = grants_due.pop_front();
                if (got !== want) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp off=%h st=%0d ffl=%0d got off=%h st=%0d ffl=%0d",
                                 want.offset, want.status, want.ffl,
                                 got.offset, got.status, got.ffl);
                end
            end
        end
    end

    // receiver backpressure
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rx) m_axis_tready <= 1'b0;
            else if (!quiet && stall_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(posedge i_clk);
            end else m_axis_tready <= 1'b1;
        end
    end

    task automatic test_directed;
        send_request(bfara_pkg::OP_ALLOC, 32'd0, 5'd0, 32'd0);
        send_request(bfara_pkg::OP_FREE, 32'd0, 5'd0, 32'd100);
        send_request(bfara_pkg::OP_ALLOC, 32'd1, 5'd0, 32'd0);
        send_request(bfara_pkg::OP_ALLOC, 32'd100, 5'd4, 32'hFFFF_FFFF);
        send_request(bfara_pkg::OP_ALLOC, 32'hFFFF_FFFF, 5'd31, 32'd0);
        send_request(bfara_pkg::OP_ALLOC, 32'd1, 5'd31, 32'd0);
        send_request(bfara_pkg::OP_FREE, 32'd64, 5'd31, 32'd16);
        send_request(bfara_pkg::OP_FREE, 32'd32, 5'd0, 32'd200);
        send_request(bfara_pkg::OP_FREE, 32'd32, 5'd0, 32'd300);
        send_request(bfara_pkg::OP_ALLOC, 32'd8, 5'd5, 32'd0);
        send_request(bfara_pkg::OP_ALLOC, 32'd32, 5'd0, 32'd0);
        send_request(bfara_pkg::OP_FREE, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FF00);
        send_request(bfara_pkg::OP_ALLOC, 32'd16, 5'd6, 32'd0);
        for (int i = 0; i < 18; i++)
            send_request(bfara_pkg::OP_FREE, 32'd40, 5'd0, 32'h1000 + 64 * i);
        send_request(bfara_pkg::OP_ALLOC, 32'd4, 5'd3, 32'd0);
    endtask

    task automatic test_random(int n);
        logic        op;
        logic [31:0] sz;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 5))
                0: sz = $urandom;
                1: sz = 32'd0;
                default: sz = $urandom_range(1, 4096);
            endcase
            if (op == bfara_pkg::OP_FREE && rng_count > 12 && $urandom_range(0, 3) != 0)
                op = bfara_pkg::OP_ALLOC;
            send_request(op, sz,
                         $urandom_range(0, 3) == 0 ? 5'($urandom) : 5'($urandom_range(0, 8)),
                         $urandom_range(0, 1) ? $urandom : $urandom_range(0, 65535));
        end
    endtask

    task automatic test_backpressure;
        hold_rx = 1'b1;
        fork
            repeat (60) @(posedge i_clk);
            test_random(6);
        join_any
        hold_rx = 1'b0;
        wait fork;
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        hold_rx = 1'b0;
        quiet = 1'b0;
        stall_on = 1'b1;
        pool_bytes = bfara_pkg::PoolSizeReset;
        bump_ptr = '0;
        rng_count = 0;
        n_err = 0;
        n_sent = 0;
        n_seen = 0;
        n_list_hits = 0;
        n_exhaust = 0;
        n_full = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(100);
        test_backpressure();
        write_pool(32'd1);
        test_random(30);
        write_pool(32'hFFFF_FFFF);
        test_random(120);
        write_pool(32'd300000);
        test_random(100);
        quiet = 1'b1;
        test_random(70);
        drain();
        repeat (20) @(posedge i_clk);
        $display("sent %0d requests, checked %0d results", n_sent, n_seen);
        $display("list grants %0d, exhausted %0d, list full on alloc %0d",
                 n_list_hits, n_exhaust, n_full);
        if (n_err == 0 && grants_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

FILE: best_fit_aligned_range_allocator.f
sv/bfara_pkg.sv
sv/bfara_cell.sv
sv/best_fit_aligned_range_allocator.sv
sv/bfara_checker.sv
verif/tb_best_fit_aligned_range_allocator.sv
